// ===== design/obd_response_line_decoder_assert.svh =====
// Assertion macros used by the PID decoder module.
`ifndef OBD_RESPONSE_LINE_DECODER_ASSERT_SVH
`define OBD_RESPONSE_LINE_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ORD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ORD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ord_pkg.sv =====
// Types, constants and helper functions of the response line decoder.
package ord_pkg;

  localparam int NUM_PAT    = 6;
  localparam int PAT_MAXLEN = 11;
  localparam int NUM_PID    = 9;
  localparam int NUM_SLOT   = 3;

  localparam logic [1:0] CLS_FILTERED = 2'd0;
  localparam logic [1:0] CLS_DECODED  = 2'd1;
  localparam logic [1:0] CLS_RESP     = 2'd2;
  localparam logic [1:0] CLS_OTHER    = 2'd3;

  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_4   = 8'h34;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [6:0] LEN_MAX = 7'd127;
  localparam logic [2:0] TOK_MAX = 3'd7;

  localparam logic [7:0] PID_04 = 8'h04;
  localparam logic [7:0] PID_05 = 8'h05;
  localparam logic [7:0] PID_06 = 8'h06;
  localparam logic [7:0] PID_07 = 8'h07;
  localparam logic [7:0] PID_0C = 8'h0C;
  localparam logic [7:0] PID_0D = 8'h0D;
  localparam logic [7:0] PID_0E = 8'h0E;
  localparam logic [7:0] PID_0F = 8'h0F;
  localparam logic [7:0] PID_21 = 8'h21;

  // AT, OK, >, ELM, SENDING..., BUS INIT...
  localparam logic [7:0] PAT_CHR [NUM_PAT][PAT_MAXLEN] = '{
    '{8'h41, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h45, 8'h4C, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h45, 8'h4E, 8'h44, 8'h49, 8'h4E, 8'h47, 8'h2E, 8'h2E, 8'h2E, 8'h00},
    '{8'h42, 8'h55, 8'h53, 8'h20, 8'h49, 8'h4E, 8'h49, 8'h54, 8'h2E, 8'h2E, 8'h2E}
  };
  localparam logic [6:0] PAT_LEN [NUM_PAT] = '{7'd2, 7'd2, 7'd1, 7'd3, 7'd10, 7'd11};
  localparam logic [NUM_PAT-1:0] PAT_PREFIX = 6'b001001;

  typedef struct packed {
    logic [1:0] cls;
    logic       pid_ok;
    logic [7:0] pid;
    logic       ab_ok;
    logic [7:0] a;
    logic [7:0] b;
  } ord_line_t;

  function automatic logic [7:0] pat_chr(input int k, input logic [6:0] pos);
    logic [7:0] r;
    r = 8'h00;
    if (pos < 7'(PAT_MAXLEN)) r = PAT_CHR[k][pos[3:0]];
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13) || (c == 8'h85) || (c == 8'hA0);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
    if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
    return d[3:0];
  endfunction

endpackage

// ===== design/ord_if.sv =====
// Valid/ready channel interfaces for characters and decoded results.
interface ord_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

interface ord_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  line_class;
  logic        [7:0]  pid;
  logic signed [16:0] value;
  logic               changed;
  modport source (output valid, output line_class, output pid, output value,
                  output changed, input ready);
  modport sink (input valid, input line_class, input pid, input value,
                input changed, output ready);
endinterface

// ===== design/obd_response_line_decoder.sv =====
// Top level of the OBD-II mode 01 response line decoder.
//
//  channel | dir | word                                   | handshake
//  in_ch   | in  | rx_char[7:0]                           | valid/ready
//  out_ch  | out | line_class[1:0] pid[7:0] value[16:0] changed | valid/ready
//
// One character is taken per cycle unless the pipeline stalls; a line's newline goes
// through the character register, line summary register and result register in turn.
// Synchronous active-low reset clears line state and all nine stored values.
// A stalled result holds; characters keep flowing until the summary stage is full.
module obd_response_line_decoder import ord_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ord_in_if.sink    in_ch,
  ord_out_if.source out_ch
);

  logic      sum_valid, sum_ready;
  ord_line_t sum_data;

  ord_line_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data)
  );

  ord_pid_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== design/ord_line_parser.sv =====
// Per-character line state: trimming, filter patterns, tokens, line summary.
module ord_line_parser import ord_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ord_in_if.sink    in_ch,
  output logic      sum_valid,
  input  logic      sum_ready,
  output ord_line_t sum_data
);

  logic [7:0]         chr_r;
  logic               chv_r;
  logic               sum_v_r, sum_v_nxt;
  ord_line_t          sum_d_r, sum_d_nxt;

  logic [6:0]         tl_r, tl_nxt;
  logic [NUM_PAT-1:0] pf_r, pf_nxt;
  logic               hdr_r, hdr_nxt;
  logic [2:0]         ti_r, ti_nxt;
  logic               acc_v_r, acc_v_nxt;
  logic [7:0]         acc_val_r, acc_val_nxt;
  logic [NUM_SLOT-1:0] tok_v_r, tok_v_nxt;
  logic [7:0]         tok_val_r [NUM_SLOT];
  logic [7:0]         tok_val_nxt [NUM_SLOT];
  logic [6:0]         run_len_r, run_len_nxt;
  logic               run_all_sp_r, run_all_sp_nxt;
  logic               run_has_sp_r, run_has_sp_nxt;
  logic               run_ns_before_r, run_ns_before_nxt;
  logic               run_ns_since_r, run_ns_since_nxt;
  logic [2:0]         run_mid_r, run_mid_nxt;
  logic [NUM_PAT-1:0] pend_kill_r, pend_kill_nxt;

  logic               s2_free, s1_adv;
  logic [7:0]         p_sum;
  logic [6:0]         p;
  logic [3:0]         t_sum;
  logic [2:0]         ti_f;
  logic               filtered, av;

  assign s2_free     = !sum_v_r || sum_ready;
  assign s1_adv      = chv_r && s2_free;
  assign in_ch.ready = !chv_r || s2_free;
  assign sum_valid   = sum_v_r;
  assign sum_data    = sum_d_r;

  assign p_sum = {1'b0, tl_r} + {1'b0, run_len_r};
  assign p     = p_sum[7] ? LEN_MAX : p_sum[6:0];

  always_comb begin
    tl_nxt = tl_r;
    pf_nxt = pf_r;
    hdr_nxt = hdr_r;
    ti_nxt = ti_r;
    acc_v_nxt = acc_v_r;
    acc_val_nxt = acc_val_r;
    tok_v_nxt = tok_v_r;
    tok_val_nxt = tok_val_r;
    run_len_nxt = run_len_r;
    run_all_sp_nxt = run_all_sp_r;
    run_has_sp_nxt = run_has_sp_r;
    run_ns_before_nxt = run_ns_before_r;
    run_ns_since_nxt = run_ns_since_r;
    run_mid_nxt = run_mid_r;
    pend_kill_nxt = pend_kill_r;
    sum_v_nxt = sum_v_r && !sum_ready;
    sum_d_nxt = sum_d_r;
    t_sum = '0;
    ti_f = '0;
    filtered = 1'b0;
    av = 1'b0;
    if (s1_adv) begin
      if (chr_r == CH_NL) begin
        if (tl_r != 7'd0) begin
          // close the last token, then summarize the line
          for (int s = 0; s < NUM_SLOT; s++) begin
            if (ti_r == 3'(s + 1)) begin
              tok_v_nxt[s] = acc_v_r;
              tok_val_nxt[s] = acc_val_r;
            end
          end
          ti_f = (ti_r == TOK_MAX) ? TOK_MAX : ti_r + 3'd1;
          for (int k = 0; k < NUM_PAT; k++) begin
            if (pf_r[k] && (PAT_PREFIX[k] ? (tl_r >= PAT_LEN[k]) : (tl_r == PAT_LEN[k])))
              filtered = 1'b1;
          end
          sum_v_nxt = 1'b1;
          sum_d_nxt.cls = filtered ? CLS_FILTERED :
                          (hdr_r && tl_r >= 7'd2) ? CLS_RESP : CLS_OTHER;
          sum_d_nxt.pid_ok = (ti_f >= 3'd2) && tok_v_nxt[0];
          sum_d_nxt.pid = tok_val_nxt[0];
          sum_d_nxt.ab_ok = (ti_f >= 3'd3) && tok_v_nxt[0] && tok_v_nxt[1];
          sum_d_nxt.a = tok_val_nxt[1];
          sum_d_nxt.b = ((ti_f >= 3'd4) && tok_v_nxt[2]) ? tok_val_nxt[2] : 8'd0;
        end
        tl_nxt = '0;
        pf_nxt = '1;
        hdr_nxt = 1'b0;
        ti_nxt = '0;
        acc_v_nxt = 1'b0;
        acc_val_nxt = '0;
        tok_v_nxt = '0;
        run_len_nxt = '0;
        run_all_sp_nxt = 1'b1;
        run_has_sp_nxt = 1'b0;
        run_ns_before_nxt = 1'b0;
        run_ns_since_nxt = 1'b0;
        run_mid_nxt = '0;
        pend_kill_nxt = '0;
      end else if (is_ws(chr_r)) begin
        if (tl_r != 7'd0) begin
          for (int k = 0; k < NUM_PAT; k++) begin
            if (p < PAT_LEN[k] && pat_chr(k, p) != CH_SP) pend_kill_nxt[k] = 1'b1;
          end
          if (chr_r == CH_SP) begin
            if (!run_has_sp_r) run_has_sp_nxt = 1'b1;
            else if (run_ns_since_r && run_mid_r < 3'd7) run_mid_nxt = run_mid_r + 3'd1;
            run_ns_since_nxt = 1'b0;
          end else begin
            run_all_sp_nxt = 1'b0;
            if (!run_has_sp_r) run_ns_before_nxt = 1'b1;
            else run_ns_since_nxt = 1'b1;
          end
          if (run_len_r != LEN_MAX) run_len_nxt = run_len_r + 7'd1;
        end
      end else begin
        if (tl_r == 7'd0) begin
          acc_v_nxt = 1'b1;
          acc_val_nxt = 8'd0;
          hdr_nxt = (chr_r == CH_4);
        end else if (run_len_r != 7'd0) begin
          // white-space run inside the line
          for (int k = 0; k < NUM_PAT; k++) begin
            if (pend_kill_r[k] || (!run_all_sp_r && tl_r < PAT_LEN[k])) pf_nxt[k] = 1'b0;
          end
          if (tl_r < 7'd2) hdr_nxt = 1'b0;
          if (!run_has_sp_r) begin
            acc_v_nxt = 1'b0;
          end else begin
            av = acc_v_r && !run_ns_before_r;
            for (int s = 0; s < NUM_SLOT; s++) begin
              if (ti_r == 3'(s + 1)) begin
                tok_v_nxt[s] = av;
                tok_val_nxt[s] = acc_val_r;
              end else if (ti_r < 3'(s + 1) &&
                           4'(s + 1) <= ({1'b0, ti_r} + {1'b0, run_mid_r})) begin
                tok_v_nxt[s] = 1'b0;
              end
            end
            t_sum = {1'b0, ti_r} + {1'b0, run_mid_r} + 4'd1;
            ti_nxt = t_sum[3] ? TOK_MAX : t_sum[2:0];
            acc_v_nxt = !run_ns_since_r;
            acc_val_nxt = 8'd0;
          end
        end
        if (p == 7'd1 && hdr_nxt) hdr_nxt = (chr_r == CH_1);
        for (int k = 0; k < NUM_PAT; k++) begin
          if (p < PAT_LEN[k]) begin
            if (pat_chr(k, p) != chr_r) pf_nxt[k] = 1'b0;
          end else if (!PAT_PREFIX[k]) begin
            pf_nxt[k] = 1'b0;
          end
        end
        if (!is_hex(chr_r)) begin
          acc_v_nxt = 1'b0;
        end else if (acc_v_nxt) begin
          if (acc_val_nxt[7:4] != 4'd0) acc_v_nxt = 1'b0;
          else acc_val_nxt = {acc_val_nxt[3:0], hex_val(chr_r)};
        end
        tl_nxt = (p == LEN_MAX) ? LEN_MAX : p + 7'd1;
        run_len_nxt = '0;
        run_all_sp_nxt = 1'b1;
        run_has_sp_nxt = 1'b0;
        run_ns_before_nxt = 1'b0;
        run_ns_since_nxt = 1'b0;
        run_mid_nxt = '0;
        pend_kill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chv_r <= 1'b0;
      sum_v_r <= 1'b0;
      tl_r <= '0;
      pf_r <= '1;
      hdr_r <= 1'b0;
      ti_r <= '0;
      acc_v_r <= 1'b0;
      tok_v_r <= '0;
      run_len_r <= '0;
      run_all_sp_r <= 1'b1;
      run_has_sp_r <= 1'b0;
      run_ns_before_r <= 1'b0;
      run_ns_since_r <= 1'b0;
      run_mid_r <= '0;
      pend_kill_r <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) chv_r <= 1'b1;
      else if (s1_adv) chv_r <= 1'b0;
      sum_v_r <= sum_v_nxt;
      tl_r <= tl_nxt;
      pf_r <= pf_nxt;
      hdr_r <= hdr_nxt;
      ti_r <= ti_nxt;
      acc_v_r <= acc_v_nxt;
      tok_v_r <= tok_v_nxt;
      run_len_r <= run_len_nxt;
      run_all_sp_r <= run_all_sp_nxt;
      run_has_sp_r <= run_has_sp_nxt;
      run_ns_before_r <= run_ns_before_nxt;
      run_ns_since_r <= run_ns_since_nxt;
      run_mid_r <= run_mid_nxt;
      pend_kill_r <= pend_kill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) chr_r <= in_ch.rx_char;
    sum_d_r <= sum_d_nxt;
    acc_val_r <= acc_val_nxt;
    tok_val_r <= tok_val_nxt;
  end

endmodule

// ===== design/ord_pid_decoder.sv =====
// PID value decode, per-PID value store and the result register.
`include "obd_response_line_decoder_assert.svh"

module ord_pid_decoder import ord_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      sum_valid,
  output logic      sum_ready,
  input  ord_line_t sum_data,
  ord_out_if.source out_ch
);

  logic               out_v_r;
  logic [1:0]         cls_r;
  logic [7:0]         pid_r;
  logic signed [16:0] val_r;
  logic               chg_r;
  logic signed [16:0] store_r [NUM_PID];

  logic               load, known, is_dec;
  logic [3:0]         idx;
  logic [7:0]         a, b;
  logic signed [16:0] v;
  logic [14:0]        x04;
  logic [30:0]        p04;
  logic [11:0]        a9, m05;
  logic [27:0]        p05;
  logic               neg05, neg06;
  logic [7:0]         d06;
  logic [14:0]        m06;

  assign sum_ready = !out_v_r || out_ch.ready;
  assign load      = sum_valid && sum_ready;
  assign a = sum_data.a;
  assign b = sum_data.b;

  always_comb begin
    known = 1'b1;
    unique case (sum_data.pid)
      PID_04: idx = 4'd0;
      PID_05: idx = 4'd1;
      PID_06: idx = 4'd2;
      PID_07: idx = 4'd3;
      PID_0C: idx = 4'd4;
      PID_0D: idx = 4'd5;
      PID_0E: idx = 4'd6;
      PID_0F: idx = 4'd7;
      PID_21: idx = 4'd8;
      default: begin
        idx = 4'd0;
        known = 1'b0;
      end
    endcase
  end

  // x/255 and m/5 by reciprocal multiply, exact over these ranges
  assign x04   = 15'(a) * 15'd100;
  assign p04   = 31'(x04) * 31'h8081;
  assign a9    = {1'b0, a, 3'b000} + 12'(a);
  assign neg05 = a9 < 12'd200;
  assign m05   = neg05 ? 12'd200 - a9 : a9 - 12'd200;
  assign p05   = 28'(m05) * 28'hCCCD;
  assign neg06 = !a[7];
  assign d06   = a[7] ? a - 8'd128 : 8'd128 - a;
  assign m06   = 15'(d06) * 15'd100;

  always_comb begin
    unique case (sum_data.pid)
      PID_04: v = $signed({9'd0, p04[30:23]});
      PID_05, PID_0F: v = neg05 ? -$signed({7'd0, p05[27:18]}) : $signed({7'd0, p05[27:18]});
      PID_06, PID_07: v = neg06 ? -$signed({9'd0, m06[14:7]}) : $signed({9'd0, m06[14:7]});
      PID_0C: v = $signed({3'd0, a, b[7:2]});
      PID_0D: v = $signed({9'd0, a});
      PID_0E: v = neg06 ? -$signed({10'd0, d06[7:1]}) : $signed({10'd0, d06[7:1]});
      PID_21: v = $signed({1'b0, a, b});
      default: v = '0;
    endcase
  end

  assign is_dec = (sum_data.cls == CLS_RESP) && sum_data.ab_ok && known;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      for (int i = 0; i < NUM_PID; i++) store_r[i] <= '0;
    end else begin
      if (load) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
      if (load && is_dec) store_r[idx] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cls_r <= is_dec ? CLS_DECODED : sum_data.cls;
      pid_r <= (sum_data.cls == CLS_RESP && sum_data.pid_ok) ? sum_data.pid : 8'd0;
      val_r <= is_dec ? v : '0;
      chg_r <= is_dec && (store_r[idx] != v);
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.line_class = cls_r;
  assign out_ch.pid        = pid_r;
  assign out_ch.value      = val_r;
  assign out_ch.changed    = chg_r;

  `ORD_ASSERT_IMP(a_value_only_decoded, out_v_r && cls_r != CLS_DECODED, val_r == '0 && !chg_r, "value or changed set on a line that was not decoded")
  `ORD_ASSERT_IMP(a_pid_only_resp, out_v_r && (cls_r == CLS_FILTERED || cls_r == CLS_OTHER), pid_r == 8'd0, "pid set on a non-response line")
  `ORD_ASSERT_NXT(a_store_written, load && is_dec, store_r[$past(idx)] == $past(v), "decoded value not stored")

endmodule
